FILE: rtl/rrs_pkg.sv
// Shared constants, types and score function of the resource requirement scorer.
`default_nettype none

package rrs_pkg;

    localparam int ADDR_WIDTH = 64;              // 16 .. 64
    localparam int IN_W       = 64;              // address field width on the port
    localparam int NBYTES     = (ADDR_WIDTH + 7) / 8;
    localparam int SCORE_W    = 17;

    localparam logic [SCORE_W-1:0] WEIGHT = SCORE_W'(256);

    typedef logic [ADDR_WIDTH-1:0] addr_t;

    // Data word carried down the divide chain
    typedef struct packed {
        addr_t rem;    // partial remainder
        addr_t quo;    // dividend bits shifting out, quotient bits shifting in
        addr_t dvsr;   // divisor (alignment, zero already mapped to one)
        addr_t aux;    // span before round-up correction
        logic  flag;   // preferred / alternative
    } rrs_div_t;

    // Highest nonzero byte plus 0x100, shifted by its byte index; -1 for zero; 256 less when flag is set
    function automatic logic [SCORE_W-1:0] rrs_score(input addr_t cnt, input logic flag);
        logic [NBYTES*8-1:0] cp;
        logic [SCORE_W-1:0]  s;
        logic                found;
        cp    = (NBYTES*8)'(cnt);
        s     = '1;
        found = 1'b0;
        for (int i = NBYTES - 1; i >= 0; i--)
        begin
            if (!found && (cp[8*i +: 8] != 8'd0))
            begin
                s     = SCORE_W'({1'b1, cp[8*i +: 8]}) << i;
                found = 1'b1;
            end
        end
        if (flag)
        begin
            s = s - WEIGHT;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rrs_req_if.sv
// Requirement channel: valid/ready with the decoded requirement fields.
`default_nettype none

interface rrs_req_if import rrs_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] min_address;
    logic [IN_W-1:0] max_address;
    logic [IN_W-1:0] req_length;
    logic [IN_W-1:0] req_alignment;
    logic            is_preferred_or_alt;

    modport source (
        output valid, min_address, max_address, req_length, req_alignment,
               is_preferred_or_alt,
        input  ready
    );
    modport sink (
        input  valid, min_address, max_address, req_length, req_alignment,
               is_preferred_or_alt,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/rrs_score_if.sv
// Score channel: valid/ready with the signed flexibility score.
`default_nettype none

interface rrs_score_if import rrs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;

    modport source (output valid, score, input ready);
    modport sink (input valid, score, output ready);
endinterface

`default_nettype wire

FILE: rtl/rrs_div_cell.sv
// One restoring-division cell: retires one quotient bit per beat.
`default_nettype none

module rrs_div_cell import rrs_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire rrs_div_t in_data,
    output logic          out_valid,
    output rrs_div_t      out_data
);

    logic [ADDR_WIDTH:0] rem_sh;
    logic [ADDR_WIDTH:0] dvsr_x;
    logic [ADDR_WIDTH:0] diff;
    logic                ge;
    logic                valid_reg;
    rrs_div_t            data_reg;
    rrs_div_t            data_next;

    assign rem_sh = {in_data.rem, in_data.quo[ADDR_WIDTH-1]};
    assign dvsr_x = {1'b0, in_data.dvsr};
    assign ge     = (rem_sh >= dvsr_x);
    assign diff   = rem_sh - dvsr_x;

    always_comb
    begin
        data_next     = in_data;
        data_next.rem = ge ? diff[ADDR_WIDTH-1:0] : rem_sh[ADDR_WIDTH-1:0];
        data_next.quo = {in_data.quo[ADDR_WIDTH-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/rrs_out_skid.sv
// Two-entry output buffer; full is registered and stalls the cell chain.
`default_nettype none

module rrs_out_skid import rrs_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [SCORE_W-1:0] push_data,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [SCORE_W-1:0]      out_data
);

    logic [SCORE_W-1:0] ent_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign out_data  = ent_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/resource_requirement_score_core.sv
// Top level: flexibility score of an address requirement, two divide-cell chains.
//
//  channel | dir | beat contents                                        | handshake
//  --------+-----+------------------------------------------------------+------------
//  req     | in  | min/max address, length, alignment, pref/alt flag    | valid/ready
//  rsp     | out | score, 17-bit two's complement                       | valid/ready
//
// One requirement per cycle while the output buffer is not full. A beat passes through
// two rows of ADDR_WIDTH one-bit divide cells, a correction stage between them and
// a count stage at the end, and is then written into the output buffer.
// Reset clears only valid bits and buffer pointers and count; data registers are not reset.
// The whole row advances together while the two-entry output buffer is not
// full; req.ready is that registered condition, so nothing is dropped on stall.
`default_nettype none

module resource_requirement_score_core import rrs_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    rrs_req_if.sink   req,
    rrs_score_if.source rsp
);

    logic en;
    logic skid_full;

    // ---- front: mask to address width, zero alignment -> one ----
    addr_t lo, hi, len, al_raw, al;
    addr_t aux_in;

    assign lo     = req.min_address[ADDR_WIDTH-1:0];
    assign hi     = req.max_address[ADDR_WIDTH-1:0];
    assign len    = req.req_length[ADDR_WIDTH-1:0];
    assign al_raw = req.req_alignment[ADDR_WIDTH-1:0];
    assign al     = (al_raw == '0) ? ADDR_WIDTH'(1) : al_raw;
    // placements span measured from the unrounded minimum
    assign aux_in = hi - len + ADDR_WIDTH'(1) - lo;

    assign en        = !skid_full;
    assign req.ready = en;

    // ---- first row: lo / al, remainder drives the round-up ----
    rrs_div_t c1_data  [0:ADDR_WIDTH];
    logic     c1_valid [0:ADDR_WIDTH];

    assign c1_valid[0] = req.valid;
    assign c1_data[0]  = '{rem: '0, quo: lo, dvsr: al, aux: aux_in,
                           flag: req.is_preferred_or_alt};

    for (genvar g = 0; g < ADDR_WIDTH; g++)
    begin : g_row1
        rrs_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (c1_valid[g]),
            .in_data  (c1_data[g]),
            .out_valid(c1_valid[g+1]),
            .out_data (c1_data[g+1])
        );
    end

    // ---- correction: aligned start = lo + (al - rem) when rem != 0 ----
    addr_t    r1, adj, span;
    logic     mid_valid_reg;
    rrs_div_t mid_reg, mid_next;

    assign r1   = c1_data[ADDR_WIDTH].rem;
    assign adj  = (r1 == '0) ? '0 : (c1_data[ADDR_WIDTH].dvsr - r1);
    assign span = c1_data[ADDR_WIDTH].aux - adj;

    always_comb
    begin
        mid_next = '{rem: '0, quo: span, dvsr: c1_data[ADDR_WIDTH].dvsr, aux: '0,
                     flag: c1_data[ADDR_WIDTH].flag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mid_valid_reg <= c1_valid[ADDR_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg <= mid_next;
        end
    end

    // ---- second row: span / al ----
    rrs_div_t c2_data  [0:ADDR_WIDTH];
    logic     c2_valid [0:ADDR_WIDTH];

    assign c2_valid[0] = mid_valid_reg;
    assign c2_data[0]  = mid_reg;

    for (genvar g = 0; g < ADDR_WIDTH; g++)
    begin : g_row2
        rrs_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (c2_valid[g]),
            .in_data  (c2_data[g]),
            .out_valid(c2_valid[g+1]),
            .out_data (c2_data[g+1])
        );
    end

    // ---- count stage: quotient + 1 ----
    logic  cnt_valid_reg;
    addr_t cnt_reg, cnt_next;
    logic  flag_reg;

    assign cnt_next = c2_data[ADDR_WIDTH].quo + ADDR_WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            cnt_valid_reg <= c2_valid[ADDR_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt_reg  <= cnt_next;
            flag_reg <= c2_data[ADDR_WIDTH].flag;
        end
    end

    // ---- byte-log score into the output buffer ----
    logic [SCORE_W-1:0] score_next;
    logic [SCORE_W-1:0] skid_data;

    assign score_next = rrs_score(cnt_reg, flag_reg);

    rrs_out_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (en && cnt_valid_reg),
        .push_data(score_next),
        .full     (skid_full),
        .out_valid(rsp.valid),
        .out_ready(rsp.ready),
        .out_data (skid_data)
    );

    assign rsp.score = $signed(skid_data);

endmodule

`default_nettype wire

FILE: rtl/rrs_checker.sv
// Port-level checks of the scorer, bound to the top level.
`default_nettype none

module rrs_checker import rrs_pkg::*; (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic signed [SCORE_W-1:0] rsp_score
);

    // a stalled beat stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    // a stalled beat keeps its score
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_score))
        else $error("rsp score changed while stalled");

    // only -1, -257 or a positive score up to 0xFF80 can come out
    a_score_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_score == -1 || rsp_score == -257 ||
                       (rsp_score >= 1 && rsp_score <= 65408)))
        else $error("score outside legal set");

    // nothing offered after reset has been sampled
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("rsp valid during reset");

endmodule

bind resource_requirement_score_core rrs_checker u_rrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_score(rsp.score)
);

`default_nettype wire
